/* rtl/core/rbnh_pkg.sv */
package rbnh_pkg;

  localparam int ENTRIES_DEF = 16;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_CAST  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         slot;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        half_w;
    logic [30:0]        half_h;
    logic signed [31:0] ray_x;
    logic signed [31:0] ray_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic [30:0]        max_dist;
  } cmd_t;

  typedef struct packed {
    logic               hit;
    logic [3:0]         hit_slot;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
  } res_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        hw;
    logic [30:0]        hh;
  } box_t;

  // 52-bit dividend (offset << 16, |offset| < 2^34), 32-bit divisor
  localparam int DVD_W = 52;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* rtl/core/ray_box_nearest_hit.sv */
// channel  | handshake          | payload
// cmd      | start / busy       | cmd (cmd_t)
// result   | done strobe        | result (res_t)
// Write and clear go from S_IDLE to S_OUT, which raises the registered strobe.
// A ray cast reads every entry in turn (S_RD, S_WAIT); an empty entry goes straight
// to S_NEXT, an occupied one runs up to four divisions, two per axis, on the shared
// serial divider (S_EVAL, S_DIVW, S_AXIS) and then S_DECIDE before S_NEXT.
// Synchronous reset clears all occupied flags at once; busy is low after reset.
// The result strobe lasts one cycle and cannot be held off.
module ray_box_nearest_hit
  import rbnh_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output res_t result
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_EVAL, S_DIVW, S_AXIS, S_DECIDE, S_NEXT, S_OUT
  } state_t;

  state_t state;
  cmd_t   c;
  logic [AW:0] idx;
  box_t   bx;
  box_t   wr_box;
  logic   occ_q;
  logic   wr_en, clr_en;
  logic [1:0] k;          // division step: 0 x lo, 1 x hi, 2 y lo, 3 y hi
  logic signed [63:0] tmin, tmax, best, t1;
  logic   miss;
  logic   div_go, div_done;
  logic signed [DVD_W-1:0] dvd;
  logic signed [31:0] dsr, quot;
  logic signed [34:0] lo_x, hi_x, lo_y, hi_y, org, lo, hi;
  logic signed [31:0] dir;

  assign wr_box = {c.center_x, c.center_y, c.half_w, c.half_h};

  rbnh_table #(.ENTRIES(ENTRIES)) u_tab (
    .clk, .rst, .wr_en, .clr_en,
    .wr_addr(AW'(c.slot)),
    .wr_data(wr_box),
    .rd_addr(idx[AW-1:0]), .rd_data(bx), .rd_occ(occ_q)
  );

  rbnh_div u_div (.clk, .rst, .go(div_go), .dividend(dvd), .divisor(dsr),
                  .done(div_done), .quot(quot));

  assign lo_x = 35'(bx.cx) - 35'($signed({1'b0, bx.hw}));
  assign hi_x = 35'(bx.cx) + 35'($signed({1'b0, bx.hw}));
  assign lo_y = 35'(bx.cy) - 35'($signed({1'b0, bx.hh}));
  assign hi_y = 35'(bx.cy) + 35'($signed({1'b0, bx.hh}));
  assign org  = k[1] ? 35'(c.ray_y) : 35'(c.ray_x);
  assign dir  = k[1] ? c.dir_y : c.dir_x;
  assign lo   = k[1] ? lo_y : lo_x;
  assign hi   = k[1] ? hi_y : hi_x;
  assign dvd  = DVD_W'((k[0] ? hi : lo) - org) <<< 16;
  assign dsr  = dir;
  assign busy = (state != S_IDLE);

  // tmin never leaves [0, 2^31 - 1], so 33 signed bits carry it
  logic signed [32:0] tmin_s;
  logic signed [63:0] px, py;
  assign tmin_s = {1'b0, tmin[31:0]};
  assign px = 64'(c.ray_x) + ((c.dir_x * tmin_s) / 65536);
  assign py = 64'(c.ray_y) + ((c.dir_y * tmin_s) / 65536);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      wr_en  <= 1'b0;
      clr_en <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      wr_en  <= 1'b0;
      clr_en <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          c <= cmd;
          result <= '0;
          idx <= '0;
          best <= 64'(cmd.max_dist);
          if (cmd.func == FUNC_CAST) state <= S_RD;
          else begin
            if ({28'd0, cmd.slot} < 32'(ENTRIES)) begin
              wr_en  <= (cmd.func == FUNC_WRITE);
              clr_en <= (cmd.func == FUNC_CLEAR);
            end
            state <= S_OUT;
          end
        end
        S_RD:   state <= S_WAIT;
        S_WAIT: begin
          tmin <= '0; tmax <= best; miss <= 1'b0; k <= 2'd0;
          state <= occ_q ? S_EVAL : S_NEXT;
        end
        S_EVAL: begin
          if (dir == 0) begin
            if (org < lo || org > hi) miss <= 1'b1;
            k <= k + 2'd2;
            state <= (k[1] || (org < lo || org > hi)) ? S_DECIDE : S_EVAL;
          end else begin
            div_go <= 1'b1;
            state <= S_DIVW;
          end
        end
        S_DIVW: if (div_done) begin
          if (!k[0]) begin
            t1 <= 64'(quot);
            k <= k + 2'd1;
            div_go <= 1'b1;
          end else state <= S_AXIS;
        end
        S_AXIS: begin
          if ((t1 < 64'(quot) ? t1 : 64'(quot)) > tmin)
            tmin <= (t1 < 64'(quot)) ? t1 : 64'(quot);
          if ((t1 < 64'(quot) ? 64'(quot) : t1) < tmax)
            tmax <= (t1 < 64'(quot)) ? 64'(quot) : t1;
          k <= k + 2'd1;
          state <= k[1] ? S_DECIDE : S_EVAL;
        end
        S_DECIDE: begin
          if (!miss && tmin < tmax && tmin < best) begin
            best <= tmin;
            result.hit <= 1'b1;
            result.hit_slot <= 4'(idx);
            result.hit_x <= sat32(px);
            result.hit_y <= sat32(py);
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          idx <= idx + 1'b1;
          state <= (idx == (AW+1)'(ENTRIES - 1)) ? S_OUT : S_RD;
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/rbnh_div.sv */
// Signed restoring divider, one quotient bit per cycle, truncating, saturated to 32 bits.
module rbnh_div
  import rbnh_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic signed [31:0]      divisor,
  output logic                    done,
  output logic signed [31:0]      quot
);
  logic [DVD_W-1:0] rem, q;
  logic [31:0]      dsr_mag;
  logic [5:0]       cnt;
  logic             neg, run;
  logic [DVD_W:0]   trial;
  logic [DVD_W-1:0] shifted;
  logic signed [DVD_W:0] sq;

  assign shifted = {rem[DVD_W-2:0], q[DVD_W-1]};
  assign trial   = {1'b0, shifted} - {{(DVD_W-31){1'b0}}, dsr_mag};

  always_comb begin
    sq = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    quot = sat32(64'(sq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run     <= 1'b1;
        cnt     <= 6'(DVD_W);
        rem     <= '0;
        q       <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
        dsr_mag <= divisor[31] ? 32'(-divisor) : 32'(divisor);
        neg     <= dividend[DVD_W-1] ^ divisor[31];
      end else if (run) begin
        if (trial[DVD_W]) begin
          rem <= shifted;
          q   <= {q[DVD_W-2:0], 1'b0};
        end else begin
          rem <= trial[DVD_W-1:0];
          q   <= {q[DVD_W-2:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/core/rbnh_table.sv */
// Box table: occupied flags in flops, box data in a synchronous memory with registered read.
module rbnh_table
  import rbnh_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic          clr_en,
  input  logic [AW-1:0] wr_addr,
  input  box_t          wr_data,
  input  logic [AW-1:0] rd_addr,
  output box_t          rd_data,
  output logic          rd_occ
);
  box_t mem [ENTRIES];
  logic [ENTRIES-1:0] occ;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      rd_occ <= 1'b0;
    end else begin
      if (wr_en) occ[wr_addr] <= 1'b1;
      else if (clr_en) occ[wr_addr] <= 1'b0;
      rd_occ <= occ[rd_addr];
    end
  end
endmodule

/* rtl/core/rbnh_checker.sv */
module rbnh_checker
  import rbnh_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input res_t result
);
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");
  a_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("double strobe");
  a_take: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("transfer not taken");
  a_miss: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> result.hit_slot == 4'd0)
    else $error("slot on miss");
endmodule

bind ray_box_nearest_hit rbnh_checker u_chk (.*);

/* test/tb_ray_box_nearest_hit.sv */
module tb_ray_box_nearest_hit;
  timeunit 1ns;
  timeprecision 1ps;
  import rbnh_pkg::*;

  // Tracks the box table and queues the answer each command must produce.
  class hit_scoreboard;
    bit     used[16];
    longint bx[16], by[16], bw[16], bh[16];
    res_t   pending[$];
    int     errors;
    int     rays, hits;

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // one axis of the slab test; returns 0 only when the direction is zero and the origin lies outside the slab
    function bit slab(longint org, longint dir, longint lo, longint hi,
                      inout longint tmin, inout longint tmax);
      longint t1, t2, tmp;
      if (dir == 0) return !(org < lo || org > hi);
      t1 = clip32(((lo - org) * 65536) / dir);
      t2 = clip32(((hi - org) * 65536) / dir);
      if (t1 > t2) begin
        tmp = t1;
        t1 = t2;
        t2 = tmp;
      end
      if (t1 > tmin) tmin = t1;
      if (t2 < tmax) tmax = t2;
      return 1;
    endfunction

    function void note(cmd_t c);
      res_t   r;
      longint ox, oy, dx, dy, best, tmin, tmax;
      r = '0;
      if (c.func == FUNC_WRITE) begin
        used[c.slot] = 1;
        bx[c.slot] = c.center_x;
        by[c.slot] = c.center_y;
        bw[c.slot] = c.half_w;
        bh[c.slot] = c.half_h;
      end else if (c.func == FUNC_CLEAR) begin
        used[c.slot] = 0;
      end else if (c.func == FUNC_CAST) begin
        rays++;
        ox = c.ray_x;
        oy = c.ray_y;
        dx = c.dir_x;
        dy = c.dir_y;
        best = c.max_dist;
        for (int i = 0; i < 16; i++) begin
          if (!used[i]) continue;
          tmin = 0;
          tmax = best;
          if (!slab(ox, dx, bx[i] - bw[i], bx[i] + bw[i], tmin, tmax)) continue;
          if (!slab(oy, dy, by[i] - bh[i], by[i] + bh[i], tmin, tmax)) continue;
          if (tmin < tmax && tmin < best) begin
            best = tmin;
            r.hit = 1;
            r.hit_slot = 4'(i);
            r.hit_x = 32'(clip32(ox + (dx * tmin) / 65536));
            r.hit_y = 32'(clip32(oy + (dy * tmin) / 65536));
          end
        end
        if (r.hit) hits++;
      end
      pending = {pending, r};
    endfunction

    function void check(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
        errors++;
      end
      if (got.hit_slot !== want.hit_slot) begin
        $display("%0t: hit_slot expected %0d actual %0d", $time, want.hit_slot, got.hit_slot);
        errors++;
      end
      if (got.hit_x !== want.hit_x) begin
        $display("%0t: hit_x expected %0d actual %0d", $time, want.hit_x, got.hit_x);
        errors++;
      end
      if (got.hit_y !== want.hit_y) begin
        $display("%0t: hit_y expected %0d actual %0d", $time, want.hit_y, got.hit_y);
        errors++;
      end
    endfunction
  endclass

  localparam longint CYCLE_LIMIT = 6000000;
  localparam int ONE = 65536;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  cmd_t cmd = '0;
  logic busy, done;
  res_t result;

  hit_scoreboard sb = new();
  longint cycles = 0;
  int sent = 0;

  ray_box_nearest_hit dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(result);
  end

  // items 150..300 go out back to back
  task automatic send(cmd_t c);
    int gap;
    gap = 0;
    if ((sent < 150 || sent > 300) && $urandom_range(99) < 23) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sb.note(c);
    sent++;
  endtask

  task automatic put_box(int s, int cx, int cy, int hw, int hh);
    cmd_t c;
    c = '0;
    c.func = FUNC_WRITE;
    c.slot = 4'(s);
    c.center_x = cx;
    c.center_y = cy;
    c.half_w = 31'(hw);
    c.half_h = 31'(hh);
    send(c);
  endtask

  task automatic cast(int ox, int oy, int dx, int dy, int md);
    cmd_t c;
    c = '0;
    c.func = FUNC_CAST;
    c.ray_x = ox;
    c.ray_y = oy;
    c.dir_x = dx;
    c.dir_y = dy;
    c.max_dist = 31'(md);
    send(c);
  endtask

  task automatic drop(int s);
    cmd_t c;
    c = '0;
    c.func = FUNC_CLEAR;
    c.slot = 4'(s);
    send(c);
  endtask

  function automatic int small_coord(int span);
    return $signed($urandom_range(0, 2 * span * ONE)) - span * ONE;
  endfunction

  initial begin
    cmd_t c;
    int pick;
    logic [351:0] raw;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed part
    cast(0, 0, ONE, 0, 100 * ONE);                       // empty table
    put_box(3, 10 * ONE, 0, 2 * ONE, 2 * ONE);
    put_box(7, 10 * ONE, 0, 2 * ONE, 2 * ONE);           // identical box, lower slot wins
    cast(0, 0, ONE, 0, 100 * ONE);
    cast(0, 0, ONE, 0, 8 * ONE);                         // max distance reached at edge
    cast(10 * ONE, 5 * ONE, 0, -ONE, 100 * ONE);         // zero x direction, inside slab
    cast(12 * ONE, 5 * ONE, 0, -ONE, 100 * ONE);         // zero x direction, on edge
    cast(13 * ONE, 5 * ONE, 0, -ONE, 100 * ONE);         // zero x direction, outside
    cast(10 * ONE, 0, 0, 0, 31'h7fffffff);               // origin inside, zero direction
    drop(3);
    cast(0, 0, ONE, 0, 31'h7fffffff);
    put_box(7, -20 * ONE, 3 * ONE, ONE, ONE);            // rewrite occupied slot
    cast(0, 0, -ONE, 0, 100 * ONE);
    cast(0, 3 * ONE, -ONE, 0, 100 * ONE);
    put_box(0, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 31'h7fffffff);
    put_box(15, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 0);
    cast(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 31'h7fffffff);
    cast(32'h7fffffff, 32'h80000000, 1, -1, 31'h7fffffff);
    cast(0, 0, 32'h80000000, 32'h7fffffff, 0);
    c = '1;
    send(c);                                             // no-op with every bit set
    drop(0);
    drop(15);
    cast(32'h80000000, 0, ONE, 0, 31'h7fffffff);

    // random part: mostly small scenes so rays actually land on boxes
    repeat (480) begin
      pick = $urandom_range(99);
      c = '0;
      if (pick < 8) begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        c = raw[$bits(cmd_t)-1:0];
        if (c.func == FUNC_CAST && $urandom_range(1))
          c.max_dist = 31'($urandom_range(0, 2000 * ONE));
        send(c);
      end else if (pick < 40) begin
        put_box($urandom_range(15), small_coord(100), small_coord(100),
                $urandom_range(0, 30 * ONE), $urandom_range(0, 30 * ONE));
      end else if (pick < 48) begin
        drop($urandom_range(15));
      end else if (pick < 51) begin
        c.func = FUNC_NOP;
        c.slot = 4'($urandom);
        send(c);
      end else begin
        cast(small_coord(200), small_coord(200),
             $urandom_range(3) == 0 ? 0 : small_coord(4),
             $urandom_range(3) == 0 ? 0 : small_coord(4),
             $urandom_range(3) == 0 ? 31'h7fffffff : $urandom_range(0, 1000 * ONE));
      end
    end

    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
    $display("%0d commands sent, %0d ray casts of which %0d hit a box",
             sent, sb.rays, sb.hits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
